@@ rtl/stbu_pkg.sv @@
// ----------------------------------------------------------------------------
// stbu_pkg: shared types and constants for the soft timer bank
// Command codes, register indexes, reset values and the packed item and
// result beats used by the timer bank and the uptime top level.
// ----------------------------------------------------------------------------
package stbu_pkg;

    // Bank size and widths
    localparam int NUM_TIMERS   = 8;
    localparam int CMD_W        = 2;
    localparam int ID_W         = 8;
    localparam int COUNT_W      = 32;
    localparam int MS_W         = 31;
    localparam int SUB_W        = 16;
    localparam int SEC_W        = 32;
    localparam int PERIOD_W     = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Millisecond uptime returns to zero when it reaches this value
    localparam logic [MS_W-1:0] MS_WRAP = {MS_W{1'b1}};

    // Register reset values
    localparam logic [SUB_W-1:0]    TICKS_PER_SECOND_RST = SUB_W'(1000);
    localparam logic [PERIOD_W-1:0] LOG_PERIOD_RST       = PERIOD_W'(60);
    localparam logic [PERIOD_W-1:0] SYNC_PERIOD_RST      = PERIOD_W'(6 * 3600);
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST    = PERIOD_W'(6 * 3600);

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_CHECK = 2'd2
    } stbu_cmd_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_SECOND = 2'd0,
        REG_LOG_PERIOD       = 2'd1,
        REG_SYNC_PERIOD      = 2'd2,
        REG_SAMPLE_PERIOD    = 2'd3
    } stbu_reg_idx_t;

    // Input beat
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ID_W-1:0]    timer_id;
        logic [COUNT_W-1:0] period_ms;
    } stbu_item_t;

    // Result beat
    typedef struct packed {
        logic             timer_expired;
        logic [MS_W-1:0]  uptime_ms;
        logic [SEC_W-1:0] uptime_s;
        logic             log_event;
        logic             sync_event;
        logic             sample_event;
    } stbu_result_t;

    // Control from the top level to the timer bank, one item per cycle
    typedef struct packed {
        logic               tick;
        logic               load;
        logic               check;
        logic [ID_W-1:0]    timer_id;
        logic [COUNT_W-1:0] period_ms;
    } stbu_timer_ctrl_t;

endpackage

@@ rtl/soft_timer_bank_with_uptime_unit.sv @@
// ----------------------------------------------------------------------------
// soft_timer_bank_with_uptime_unit: countdown timers with uptime counters
// Top level: command capture, uptime and period event counters, result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item and raise start for one cycle per command; a command is taken
//   at every edge with start high and busy low. busy stays low, so a command
//   may be given in every cycle: one item per clock cycle sustained.
//   Commands: tick (1 ms step of all timers and the uptime counters), start
//   (load a timer and clear its flag), check (read and clear a done flag).
//   Each command gives one result beat on result, marked by done for exactly
//   one cycle; the command passes through the command register, then through
//   the update logic into the result register.
//   The rate is set by that single registered pass; all timers decrement in
//   parallel lanes. The receiver cannot stall: every beat must be taken in
//   the cycle that done is high.
//   The register port (cfg_we, cfg_index, cfg_data) writes at once. The user
//   must use it while no command is in flight; the block does not enforce it.
//   Reset clears all timers, flags, counters and phases, and loads the
//   register defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module soft_timer_bank_with_uptime_unit
    import stbu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  stbu_item_t            item,
    output logic                  done,
    output stbu_result_t          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Registers
    logic [SUB_W-1:0]    ticks_per_second_reg;
    logic [PERIOD_W-1:0] log_period_reg;
    logic [PERIOD_W-1:0] sync_period_reg;
    logic [PERIOD_W-1:0] sample_period_reg;

    // Command register
    logic       cmd_valid_reg;
    stbu_item_t cmd_reg;

    // Uptime state
    logic [MS_W-1:0]     ms_reg;
    logic [MS_W-1:0]     ms_next;
    logic [SUB_W-1:0]    sub_reg;
    logic [SUB_W-1:0]    sub_next;
    logic [SEC_W-1:0]    sec_reg;
    logic [SEC_W-1:0]    sec_next;
    logic [PERIOD_W-1:0] log_phase_reg;
    logic [PERIOD_W-1:0] log_phase_next;
    logic [PERIOD_W-1:0] sync_phase_reg;
    logic [PERIOD_W-1:0] sync_phase_next;
    logic [PERIOD_W-1:0] sample_phase_reg;
    logic [PERIOD_W-1:0] sample_phase_next;

    // Result register
    logic         done_reg;
    stbu_result_t result_reg;
    stbu_result_t result_next;

    logic             is_tick;
    logic [SUB_W:0]   sub_inc;
    logic             new_second;
    logic [PERIOD_W:0] log_inc;
    logic [PERIOD_W:0] sync_inc;
    logic [PERIOD_W:0] sample_inc;
    logic             log_hit;
    logic             sync_hit;
    logic             sample_hit;
    logic             expired;
    stbu_timer_ctrl_t timer_ctrl;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_second_reg <= TICKS_PER_SECOND_RST;
            log_period_reg       <= LOG_PERIOD_RST;
            sync_period_reg      <= SYNC_PERIOD_RST;
            sample_period_reg    <= SAMPLE_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (stbu_reg_idx_t'(cfg_index))
                REG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_data[SUB_W-1:0];
                REG_LOG_PERIOD:       log_period_reg       <= cfg_data;
                REG_SYNC_PERIOD:      sync_period_reg      <= cfg_data;
                REG_SAMPLE_PERIOD:    sample_period_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Capture the command beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= item;
        end
    end

    // Decode the held command for the timer bank
    assign is_tick = cmd_valid_reg && (stbu_cmd_t'(cmd_reg.command) == CMD_TICK);

    always_comb
    begin
        timer_ctrl.tick      = is_tick;
        timer_ctrl.load      = cmd_valid_reg &&
                               (stbu_cmd_t'(cmd_reg.command) == CMD_START);
        timer_ctrl.check     = cmd_valid_reg &&
                               (stbu_cmd_t'(cmd_reg.command) == CMD_CHECK);
        timer_ctrl.timer_id  = cmd_reg.timer_id;
        timer_ctrl.period_ms = cmd_reg.period_ms;
    end

    stbu_timer_bank u_timer_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (timer_ctrl),
        .expired (expired)
    );

    // Advance uptime, seconds and event phases on a tick
    assign sub_inc    = {1'b0, sub_reg} + (SUB_W + 1)'(1);
    assign new_second = (sub_inc >= {1'b0, ticks_per_second_reg});
    assign log_inc    = {1'b0, log_phase_reg} + (PERIOD_W + 1)'(1);
    assign sync_inc   = {1'b0, sync_phase_reg} + (PERIOD_W + 1)'(1);
    assign sample_inc = {1'b0, sample_phase_reg} + (PERIOD_W + 1)'(1);
    assign log_hit    = is_tick && new_second && (log_inc >= {1'b0, log_period_reg});
    assign sync_hit   = is_tick && new_second && (sync_inc >= {1'b0, sync_period_reg});
    assign sample_hit = is_tick && new_second &&
                        (sample_inc >= {1'b0, sample_period_reg});

    always_comb
    begin
        ms_next           = ms_reg;
        sub_next          = sub_reg;
        sec_next          = sec_reg;
        log_phase_next    = log_phase_reg;
        sync_phase_next   = sync_phase_reg;
        sample_phase_next = sample_phase_reg;
        if (is_tick)
        begin
            ms_next = (ms_reg + MS_W'(1) == MS_WRAP) ? '0 : ms_reg + MS_W'(1);
            if (new_second)
            begin
                sub_next          = '0;
                sec_next          = sec_reg + SEC_W'(1);
                log_phase_next    = log_hit ? '0 : log_inc[PERIOD_W-1:0];
                sync_phase_next   = sync_hit ? '0 : sync_inc[PERIOD_W-1:0];
                sample_phase_next = sample_hit ? '0 : sample_inc[PERIOD_W-1:0];
            end
            else
            begin
                sub_next = sub_inc[SUB_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg           <= '0;
            sub_reg          <= '0;
            sec_reg          <= '0;
            log_phase_reg    <= '0;
            sync_phase_reg   <= '0;
            sample_phase_reg <= '0;
        end
        else
        begin
            ms_reg           <= ms_next;
            sub_reg          <= sub_next;
            sec_reg          <= sec_next;
            log_phase_reg    <= log_phase_next;
            sync_phase_reg   <= sync_phase_next;
            sample_phase_reg <= sample_phase_next;
        end
    end

    // Build the result beat
    always_comb
    begin
        result_next.timer_expired = expired;
        result_next.uptime_ms     = ms_next;
        result_next.uptime_s      = sec_next;
        result_next.log_event     = log_hit;
        result_next.sync_event    = sync_hit;
        result_next.sample_event  = sample_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // A result beat follows a held command in the next cycle
    a_done_follows_cmd: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd_valid_reg)
    ) else $error("result beat without a held command");

    // Events fire only for a tick command
    a_event_on_tick: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (result.log_event || result.sync_event || result.sample_event))
            |-> $past(stbu_cmd_t'(cmd_reg.command) == CMD_TICK)
    ) else $error("period event on a command other than tick");

    // Expired is reported only for a check command
    a_expired_on_check: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.timer_expired)
            |-> $past(stbu_cmd_t'(cmd_reg.command) == CMD_CHECK)
    ) else $error("timer expired reported on a command other than check");

    // An event comes with a new whole second
    a_event_new_second: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && (log_hit || sync_hit || sample_hit))
            |=> (sec_reg == $past(sec_reg) + SEC_W'(1))
    ) else $error("period event without a seconds step");
`endif

endmodule

@@ rtl/stbu_timer_bank.sv @@
// ----------------------------------------------------------------------------
// stbu_timer_bank: one-shot countdown timers
// Every timer is its own lane: a count and a done flag. A tick decrements all
// running lanes at once, a load restarts one lane, a check reads and clears
// one done flag.
// ----------------------------------------------------------------------------
module stbu_timer_bank
    import stbu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stbu_timer_ctrl_t ctrl,
    output logic             expired
);

    logic [COUNT_W-1:0]    count_reg [NUM_TIMERS];
    logic [COUNT_W-1:0]    count_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] done_reg;
    logic [NUM_TIMERS-1:0] done_next;
    logic [NUM_TIMERS-1:0] sel;

    // Decode the id; ids outside the bank select no lane
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            sel[i] = (ctrl.timer_id == ID_W'(i));
        end
    end

    // Report the selected flag before the check clears it
    assign expired = ctrl.check & (|(done_reg & sel));

    // Advance each lane
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            count_next[i] = count_reg[i];
            done_next[i]  = done_reg[i];
            if (ctrl.tick && !done_reg[i] && (count_reg[i] != '0))
            begin
                count_next[i] = count_reg[i] - COUNT_W'(1);
                if (count_reg[i] == COUNT_W'(1))
                begin
                    done_next[i] = 1'b1;
                end
            end
            if (ctrl.load && sel[i])
            begin
                count_next[i] = ctrl.period_ms;
                done_next[i]  = 1'b0;
            end
            if (ctrl.check && sel[i])
            begin
                done_next[i] = 1'b0;
            end
        end
    end

    // Hold lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= '0;
            end
            done_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
            done_reg <= done_next;
        end
    end

endmodule
